FILE: rtl/core/eab_pkg.sv
package eab_pkg;

  // Field widths fixed by the item format
  localparam int unsigned RotW    = 16;
  localparam int unsigned CentreW = 24;
  localparam int unsigned RadW    = 16;
  localparam int unsigned BoundW  = 25;

  // Square root: 64-bit radicand, 32-bit root, one root bit per cell
  localparam int unsigned SumW    = 64;
  localparam int unsigned RootW   = 32;
  localparam int unsigned RemW    = 36;
  localparam int unsigned NumCells = RootW;

  // Rounding: extent = (root + RoundHalf) >> FracShift, saturated to 16 bits
  localparam int unsigned FracShift = 14;
  localparam logic [RootW:0] RoundHalf = (RootW+1)'(1) << (FracShift - 1);
  localparam int unsigned ExtW = 16;
  localparam logic [ExtW-1:0] ExtentMax = '1;

  // One input item as taken from the channel
  typedef struct packed {
    logic signed [RotW-1:0]    rot_x;
    logic signed [RotW-1:0]    rot_y;
    logic signed [RotW-1:0]    rot_z;
    logic signed [CentreW-1:0] center_coord;
    logic [RadW-1:0]           radius_a;
    logic [RadW-1:0]           radius_b;
    logic [RadW-1:0]           radius_c;
  } eab_item_t;

  // Data handed from one root cell to the next
  typedef struct packed {
    logic [RemW-1:0]           rem;
    logic [RootW-1:0]          root;
    logic [SumW-1:0]           rad;
    logic signed [CentreW-1:0] centre;
  } eab_sqrt_t;

endpackage

FILE: rtl/core/eab_if.sv
interface eab_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rot_x;
  logic signed [15:0] rot_y;
  logic signed [15:0] rot_z;
  logic signed [23:0] center_coord;
  logic [15:0]        radius_a;
  logic [15:0]        radius_b;
  logic [15:0]        radius_c;

  modport source (
    output valid, rot_x, rot_y, rot_z, center_coord, radius_a, radius_b, radius_c,
    input  ready
  );
  modport sink (
    input  valid, rot_x, rot_y, rot_z, center_coord, radius_a, radius_b, radius_c,
    output ready
  );
endinterface

interface eab_out_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] bound_low;
  logic signed [24:0] bound_high;

  modport source (
    output valid, bound_low, bound_high,
    input  ready
  );
  modport sink (
    input  valid, bound_low, bound_high,
    output ready
  );
endinterface

FILE: rtl/core/eab_front.sv
module eab_front import eab_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  eab_item_t                 item_i,
  output logic                      valid_o,
  output logic [SumW-1:0]           sum_o,
  output logic signed [CentreW-1:0] centre_o
);

  localparam int unsigned ProdW = 2 * RadW;

  logic [RotW-1:0]           mag_x, mag_y, mag_z;
  logic [3:0]                vld_q;
  logic [ProdW-1:0]          pa_q, pb_q, pc_q;
  logic [SumW-1:0]           sa_q, sb_q, sc_q;
  logic [SumW-1:0]           sab_q, sc2_q, sum_q;
  logic signed [CentreW-1:0] c1_q, c2_q, c3_q, c4_q;

  // Magnitudes of the rotation entries; the most negative code maps to 2^15
  assign mag_x = item_i.rot_x[RotW-1] ? RotW'(-item_i.rot_x) : RotW'(item_i.rot_x);
  assign mag_y = item_i.rot_y[RotW-1] ? RotW'(-item_i.rot_y) : RotW'(item_i.rot_y);
  assign mag_z = item_i.rot_z[RotW-1] ? RotW'(-item_i.rot_z) : RotW'(item_i.rot_z);

  // Advance valid bits of the four front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  // Products, squares, then a two-step sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q  <= ProdW'(mag_x) * ProdW'(item_i.radius_a);
      pb_q  <= ProdW'(mag_y) * ProdW'(item_i.radius_b);
      pc_q  <= ProdW'(mag_z) * ProdW'(item_i.radius_c);
      c1_q  <= item_i.center_coord;
      sa_q  <= SumW'(pa_q) * SumW'(pa_q);
      sb_q  <= SumW'(pb_q) * SumW'(pb_q);
      sc_q  <= SumW'(pc_q) * SumW'(pc_q);
      c2_q  <= c1_q;
      sab_q <= sa_q + sb_q;
      sc2_q <= sc_q;
      c3_q  <= c2_q;
      sum_q <= sab_q + sc2_q;
      c4_q  <= c3_q;
    end
  end

  assign valid_o  = vld_q[3];
  assign sum_o    = sum_q;
  assign centre_o = c4_q;

endmodule

FILE: rtl/core/eab_cell.sv
module eab_cell import eab_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  eab_sqrt_t data_i,
  output logic      valid_o,
  output eab_sqrt_t data_o
);

  logic [RemW-1:0] rem_sh;
  logic [RemW-1:0] trial;
  logic            fits;
  eab_sqrt_t       data_d;
  eab_sqrt_t       data_q;
  logic            valid_q;

  // Bring down the next two radicand bits and try the next root bit
  assign rem_sh = {data_i.rem[RemW-3:0], data_i.rad[SumW-1:SumW-2]};
  assign trial  = {(RemW-RootW-2)'(0), data_i.root, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_comb begin
    data_d        = data_i;
    data_d.rad    = {data_i.rad[SumW-3:0], 2'b00};
    data_d.rem    = fits ? (rem_sh - trial) : rem_sh;
    data_d.root   = {data_i.root[RootW-2:0], fits};
  end

  // Hold the valid bit under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Hand the partial root on to the neighbour
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/core/ellipsoid_axis_bounds.sv
// Channel  Dir  Modport  Transfer when   Payload
// in_i     in   sink     valid & ready   rot_x/y/z, center_coord, radius_a/b/c
// out_o    out  source   valid & ready   bound_low, bound_high
//
// One item per cycle is accepted while the output is not stalled; the chain has
// 4 front stages for products, squares and sum, 32 root cells, one rounding and
// one output stage. The depth follows from the square root, one root bit per cell.
// Reset clears the valid bits only; no state survives between items.
// A stalled output freezes the whole chain; a one-entry skid register on the
// input keeps in_i.ready registered, so one more transfer is taken on a stall.
module ellipsoid_axis_bounds import eab_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  eab_in_if.sink    in_i,
  eab_out_if.source out_o
);

  logic                      en;
  logic                      skid_full_q;
  eab_item_t                 skid_q;
  eab_item_t                 in_item;
  eab_item_t                 front_item;
  logic                      front_valid;
  logic                      sum_valid;
  logic [SumW-1:0]           sum;
  logic signed [CentreW-1:0] sum_centre;
  logic [NumCells:0]         cell_valid;
  eab_sqrt_t                 cell_data [NumCells+1];
  logic [RootW:0]            rounded;
  logic                      ext_valid_q;
  logic [ExtW-1:0]           ext_q;
  logic signed [CentreW-1:0] ext_centre_q;
  logic                      out_valid_q;
  logic signed [BoundW-1:0]  low_q, high_q;

  // Advance the chain whenever the output register is free or being drained
  assign en = !out_valid_q || out_o.ready;

  assign in_item.rot_x        = in_i.rot_x;
  assign in_item.rot_y        = in_i.rot_y;
  assign in_item.rot_z        = in_i.rot_z;
  assign in_item.center_coord = in_i.center_coord;
  assign in_item.radius_a     = in_i.radius_a;
  assign in_item.radius_b     = in_i.radius_b;
  assign in_item.radius_c     = in_i.radius_c;

  assign in_i.ready  = !skid_full_q;
  assign front_item  = skid_full_q ? skid_q : in_item;
  assign front_valid = skid_full_q || in_i.valid;

  // Park a transfer taken during a stall; drain it on the next advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
    end else if (en) begin
      skid_full_q <= 1'b0;
    end else if (in_i.valid && !skid_full_q) begin
      skid_full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && in_i.valid && !skid_full_q) begin
      skid_q <= in_item;
    end
  end

  eab_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (front_valid),
    .item_i   (front_item),
    .valid_o  (sum_valid),
    .sum_o    (sum),
    .centre_o (sum_centre)
  );

  // Seed the root chain with the full radicand
  assign cell_valid[0]       = sum_valid;
  assign cell_data[0].rem    = '0;
  assign cell_data[0].root   = '0;
  assign cell_data[0].rad    = sum;
  assign cell_data[0].centre = sum_centre;

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    eab_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cell_valid[g]),
      .data_i  (cell_data[g]),
      .valid_o (cell_valid[g+1]),
      .data_o  (cell_data[g+1])
    );
  end

  // Round the root to whole units and saturate the extent
  assign rounded = {1'b0, cell_data[NumCells].root} + RoundHalf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      ext_valid_q <= cell_valid[NumCells];
      out_valid_q <= ext_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ext_q        <= (rounded[RootW:FracShift+ExtW] != '0) ? ExtentMax
                                                            : rounded[FracShift+ExtW-1:FracShift];
      ext_centre_q <= cell_data[NumCells].centre;
      low_q        <= BoundW'(ext_centre_q) - BoundW'(ext_q);
      high_q       <= BoundW'(ext_centre_q) + BoundW'(ext_q);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.bound_low  = low_q;
  assign out_o.bound_high = high_q;

endmodule
